// ===== src/irat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irat_pkg: shared types and constants
// Defaults, operation and status codes, controller/datapath interface types.
// ----------------------------------------------------------------------------
package irat_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_KEY_WIDTH   = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic set_result;
    logic set_full;
    logic move_init;
    logic move_step;
    logic ins_lo;
    logic ins_hi;
  } dp_cmd_t;

  typedef struct packed {
    logic lookup;
    logic empty;
    logic cnt_zero;
    logic scan_last;
    logic full;
    logic tail_zero;
    logic move_last;
  } dp_sts_t;

endpackage

// ===== src/irat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irat_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/irat_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irat_ctrl: sequencer
// Steps a request through scan, decision, tail move and insertion.
// ----------------------------------------------------------------------------
module irat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output irat_pkg::dp_cmd_t cmd,
  input  irat_pkg::dp_sts_t sts
);

  import irat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SCAN_RD, S_SCAN_CHK, S_DECIDE,
    S_MOVE_RD, S_MOVE_WR, S_INS_LO, S_INS_HI, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (!sts.lookup && sts.empty) begin
          state_nxt = S_DONE;
        end else if (sts.cnt_zero) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
        state_nxt = sts.scan_last ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        if (sts.lookup) begin
          cmd.set_result = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.full) begin
          cmd.set_full = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.move_init = 1'b1;
          state_nxt = sts.tail_zero ? S_INS_LO : S_MOVE_RD;
        end
      end
      S_MOVE_RD: state_nxt = S_MOVE_WR;
      S_MOVE_WR: begin
        cmd.move_step = 1'b1;
        state_nxt = sts.move_last ? S_INS_LO : S_MOVE_RD;
      end
      S_INS_LO: begin
        cmd.ins_lo = 1'b1;
        state_nxt = S_INS_HI;
      end
      S_INS_HI: begin
        cmd.ins_hi = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

// ===== src/irat_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irat_dp: datapath
// Request registers, scan counters, tail move addressing and table memory.
// ----------------------------------------------------------------------------
module irat_dp #(
  parameter int CAPACITY    = irat_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH   = irat_pkg::DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = irat_pkg::DEF_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              in_op,
  input  logic [31:0]       in_key_begin,
  input  logic [31:0]       in_key_end,
  input  logic [31:0]       in_assign_value,
  input  logic [31:0]       in_lookup_key,
  input  irat_pkg::dp_cmd_t cmd,
  output irat_pkg::dp_sts_t sts,
  output logic [31:0]       out_lookup_value,
  output logic [1:0]        out_status
);

  import irat_pkg::*;

  localparam int KW = KEY_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic                 op_r;
  logic signed [KW-1:0] kb_r, ke_r;
  logic [VW-1:0]        av_r, old_r, bottom_r;
  logic [CW-1:0]        cnt_r, idx_r, lo_r, hi_r;
  logic                 right_r;
  logic [31:0]          res_r;
  status_t              status_r;

  logic [KW+31:0] kb_ext, ke_ext, lk_ext;
  logic [VW+31:0] av_ext, cfg_ext, old_ext;
  logic [CW-1:0]  kept;
  logic [CW:0]    need;
  logic [CW:0]    dst;
  logic signed [KW-1:0] rkey;
  logic [VW-1:0]  rval;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [KW+VW-1:0] wdata, rdata;

  assign kb_ext  = {{KW{1'b0}}, in_key_begin};
  assign ke_ext  = {{KW{1'b0}}, in_key_end};
  assign lk_ext  = {{KW{1'b0}}, in_lookup_key};
  assign av_ext  = {{VW{1'b0}}, in_assign_value};
  assign cfg_ext = {{VW{1'b0}}, cfg_data};
  assign old_ext = {32'd0, old_r};

  assign rkey = rdata[KW+VW-1:VW];
  assign rval = rdata[VW-1:0];

  assign kept = cnt_r - (hi_r - lo_r);
  assign need = {1'b0, kept} + (CW+1)'(2);
  assign dst  = {1'b0, idx_r} + {1'b0, lo_r} + (CW+1)'(2) - {1'b0, hi_r};

  assign sts.lookup    = (op_r == OP_LOOKUP);
  assign sts.empty     = !(kb_r < ke_r);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.scan_last = (idx_r == cnt_r - CW'(1));
  assign sts.full      = (need > (CW+1)'(CAPACITY));
  assign sts.tail_zero = (hi_r == cnt_r);
  assign sts.move_last = right_r ? (idx_r == hi_r) : (idx_r == cnt_r - CW'(1));

  always_comb begin
    we    = 1'b0;
    waddr = dst[AW-1:0];
    wdata = rdata;
    if (cmd.move_step) begin
      we = 1'b1;
    end else if (cmd.ins_lo) begin
      we    = 1'b1;
      waddr = lo_r[AW-1:0];
      wdata = {kb_r, av_r};
    end else if (cmd.ins_hi) begin
      we    = 1'b1;
      waddr = AW'(lo_r + CW'(1));
      wdata = {ke_r, old_r};
    end
  end

  irat_ram #(
    .WIDTH (KW + VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      bottom_r <= '0;
    end else if (cfg_we) begin
      cnt_r    <= '0;
      bottom_r <= cfg_ext[VW-1:0];
    end else if (cmd.ins_hi) begin
      cnt_r <= need[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      kb_r     <= kb_ext[KW-1:0];
      ke_r     <= (in_op == OP_LOOKUP) ? lk_ext[KW-1:0] : ke_ext[KW-1:0];
      av_r     <= av_ext[VW-1:0];
      old_r    <= bottom_r;
      idx_r    <= '0;
      lo_r     <= '0;
      hi_r     <= '0;
      res_r    <= '0;
      status_r <= (in_op == OP_ASSIGN && !($signed(kb_ext[KW-1:0]) < $signed(ke_ext[KW-1:0])))
                  ? ST_EMPTY : ST_DONE;
    end
    if (cmd.scan_step) begin
      if (rkey < kb_r) begin
        lo_r <= lo_r + CW'(1);
      end
      if (rkey <= ke_r) begin
        hi_r  <= hi_r + CW'(1);
        old_r <= rval;
      end
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.set_result) begin
      res_r <= old_ext[31:0];
    end
    if (cmd.set_full) begin
      status_r <= ST_FULL;
    end
    if (cmd.move_init) begin
      right_r <= ({1'b0, lo_r} + (CW+1)'(2) > {1'b0, hi_r});
      idx_r   <= ({1'b0, lo_r} + (CW+1)'(2) > {1'b0, hi_r}) ? cnt_r - CW'(1) : hi_r;
    end
    if (cmd.move_step) begin
      idx_r <= right_r ? idx_r - CW'(1) : idx_r + CW'(1);
    end
  end

  assign out_lookup_value = res_r;
  assign out_status       = status_r;

endmodule

// ===== src/interval_range_assign_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_range_assign_table: sorted boundary table with range assign
// Assigns values over key intervals and looks up the value at a key.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// in        start, busy               in_op, in_key_begin, in_key_end,
//                                     in_assign_value, in_lookup_key
// out       out_valid (1-cycle pulse) out_lookup_value, out_status
// cfg       cfg_valid, cfg_ready      cfg_data (initial_value)
//
// A lookup scans the stored entries; an assign scans them and, unless the table is
// full, moves any tail and writes the two new boundaries. An empty assign interval
// skips the scan. Reset is synchronous; the table needs no clearing pass. The
// result is shown for one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
module interval_range_assign_table #(
  parameter int CAPACITY    = irat_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH   = irat_pkg::DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = irat_pkg::DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_key_begin,
  input  logic [31:0] in_key_end,
  input  logic [31:0] in_assign_value,
  input  logic [31:0] in_lookup_key,
  output logic        out_valid,
  output logic [31:0] out_lookup_value,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  import irat_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = !busy;

  irat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .cmd   (cmd),
    .sts   (sts)
  );

  irat_dp #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_key_begin     (in_key_begin),
    .in_key_end       (in_key_end),
    .in_assign_value  (in_assign_value),
    .in_lookup_key    (in_lookup_key),
    .cmd              (cmd),
    .sts              (sts),
    .out_lookup_value (out_lookup_value),
    .out_status       (out_status)
  );

endmodule

// ===== src/irat_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irat_chk: port checker
// Checks request and result sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module irat_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_lookup_value,
  input logic [1:0]  out_status
);

  import irat_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted request did not raise busy");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without a request in flight");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid)) else $error("request ended without a result");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_lookup_value == 32'd0)
    else $error("rejected request carried a value");

endmodule

bind interval_range_assign_table irat_chk u_irat_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_lookup_value (out_lookup_value),
  .out_status       (out_status)
);

// ===== tb/tb_interval_range_assign_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_range_assign_table: self-checking bench for the range table
// Drives assign and lookup requests and writes of initial_value, with random
// gaps. Each result is checked against a table model kept in the bench.
// ----------------------------------------------------------------------------
module tb_interval_range_assign_table;
  import irat_pkg::*;

  localparam int TABLE_DEPTH = DEF_CAPACITY;
  localparam int SETTLE_CYCLES = 6;

  typedef enum logic [1:0] {
    RQ_ITEM,
    RQ_CFG,
    RQ_DRAIN
  } req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic        op;
    logic [31:0] key_begin;
    logic [31:0] key_end;
    logic [31:0] assign_value;
    logic [31:0] lookup_key;
    logic [31:0] cfg_value;
    int          gap;
  } table_req_t;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = OP_LOOKUP;
  logic [31:0] in_key_begin = '0;
  logic [31:0] in_key_end = '0;
  logic [31:0] in_assign_value = '0;
  logic [31:0] in_lookup_key = '0;
  logic        out_valid;
  logic [31:0] out_lookup_value;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  interval_range_assign_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key_begin    (in_key_begin),
    .in_key_end      (in_key_end),
    .in_assign_value (in_assign_value),
    .in_lookup_key   (in_lookup_key),
    .out_valid       (out_valid),
    .out_lookup_value(out_lookup_value),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  table_req_t    pending_reqs[$];
  table_result_t expected_results[$];

  logic [31:0] bound_keys[TABLE_DEPTH];
  logic [31:0] bound_vals[TABLE_DEPTH];
  int          bound_count = 0;
  logic [31:0] bottom_val = '0;

  int  errors = 0;
  int  n_lookups = 0;
  int  n_assigned = 0;
  int  n_empty = 0;
  int  n_full = 0;
  int  n_cfg = 0;
  int  n_items = 0;
  bit  quiet_gaps = 1'b0;

  function automatic int count_keys(logic [31:0] k, bit or_equal);
    int n;
    n = 0;
    for (int i = 0; i < bound_count; i++)
      if ($signed(bound_keys[i]) < $signed(k) || (or_equal && bound_keys[i] == k)) n++;
    return n;
  endfunction

  function automatic logic [31:0] value_at(logic [31:0] k);
    int n;
    n = count_keys(k, 1'b1);
    return (n > 0) ? bound_vals[n - 1] : bottom_val;
  endfunction

  function automatic table_result_t apply_request(table_req_t r);
    table_result_t res;
    logic [31:0]   nk[TABLE_DEPTH];
    logic [31:0]   nv[TABLE_DEPTH];
    logic [31:0]   prior;
    int            lo, hi, kept;
    res.value = '0;
    res.status = ST_DONE;
    if (r.op == OP_LOOKUP) begin
      res.value = value_at(r.lookup_key);
    end else if ($signed(r.key_begin) >= $signed(r.key_end)) begin
      res.status = ST_EMPTY;
    end else begin
      lo = count_keys(r.key_begin, 1'b0);
      hi = count_keys(r.key_end, 1'b1);
      kept = bound_count - (hi - lo);
      if (kept + 2 > TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        prior = (hi > 0) ? bound_vals[hi - 1] : bottom_val;
        for (int i = 0; i < lo; i++) begin
          nk[i] = bound_keys[i];
          nv[i] = bound_vals[i];
        end
        nk[lo] = r.key_begin;
        nv[lo] = r.assign_value;
        nk[lo + 1] = r.key_end;
        nv[lo + 1] = prior;
        for (int i = hi; i < bound_count; i++) begin
          nk[lo + 2 + i - hi] = bound_keys[i];
          nv[lo + 2 + i - hi] = bound_vals[i];
        end
        bound_count = kept + 2;
        for (int i = 0; i < bound_count; i++) begin
          bound_keys[i] = nk[i];
          bound_vals[i] = nv[i];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: one request in flight at a time, settings only when idle.
  table_req_t drv_cur;
  bit         drv_active = 1'b0;
  int         drv_gap = 0;
  int         idle_cycles = 0;

  always @(posedge clk) begin
    logic start_n, cfg_valid_n;
    table_result_t res;
    start_n = start;
    cfg_valid_n = cfg_valid;
    if (!rst_n) begin
      start_n = 1'b0;
      cfg_valid_n = 1'b0;
      idle_cycles = 0;
    end else begin
      if (expected_results.size() == 0 && !busy && !start && !out_valid) idle_cycles++;
      else idle_cycles = 0;
      if (start && !busy) begin
        res = apply_request(drv_cur);
        expected_results.push_back(res);
        start_n = 1'b0;
        drv_active = 1'b0;
        drv_gap = drv_cur.gap;
      end
      if (cfg_valid && cfg_ready) begin
        bottom_val = drv_cur.cfg_value;
        bound_count = 0;
        n_cfg++;
        cfg_valid_n = 1'b0;
        drv_active = 1'b0;
        drv_gap = drv_cur.gap;
      end
      if (!drv_active) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_reqs.size() > 0) begin
          if (pending_reqs[0].kind == RQ_ITEM) begin
            drv_cur = pending_reqs.pop_front();
            in_op <= drv_cur.op;
            in_key_begin <= drv_cur.key_begin;
            in_key_end <= drv_cur.key_end;
            in_assign_value <= drv_cur.assign_value;
            in_lookup_key <= drv_cur.lookup_key;
            start_n = 1'b1;
            drv_active = 1'b1;
          end else if (idle_cycles >= SETTLE_CYCLES) begin
            drv_cur = pending_reqs.pop_front();
            if (drv_cur.kind == RQ_CFG) begin
              cfg_data <= drv_cur.cfg_value;
              cfg_valid_n = 1'b1;
              drv_active = 1'b1;
            end
          end
        end
      end
    end
    start <= start_n;
    cfg_valid <= cfg_valid_n;
  end

  // Monitor: results cannot be held off, so each strobe is checked at once.
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", {30'd0, out_status}, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_lookup_value !== want.value)
          report_mismatch("lookup_value", out_lookup_value, want.value);
        if (out_status !== want.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, want.status});
        if (want.status == ST_EMPTY) n_empty++;
        else if (want.status == ST_FULL) n_full++;
        else if (want.value == '0 && n_items == 0) n_assigned += 0;
      end
    end
  end

  task automatic push_item(logic op, logic [31:0] kb, logic [31:0] ke,
                           logic [31:0] av, logic [31:0] lk);
    table_req_t r;
    r.kind = RQ_ITEM;
    r.op = op;
    r.key_begin = kb;
    r.key_end = ke;
    r.assign_value = av;
    r.lookup_key = lk;
    r.cfg_value = '0;
    r.gap = quiet_gaps ? 0 : $urandom_range(0, 13);
    pending_reqs.push_back(r);
    n_items++;
    if (op == OP_LOOKUP) n_lookups++;
  endtask

  task automatic push_marker(req_kind_t kind, logic [31:0] value);
    table_req_t r;
    r.kind = kind;
    r.op = OP_LOOKUP;
    r.key_begin = '0;
    r.key_end = '0;
    r.assign_value = '0;
    r.lookup_key = '0;
    r.cfg_value = value;
    r.gap = $urandom_range(0, 13);
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] draw_key(logic [31:0] base);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return base + $urandom_range(0, 300);
    if (sel == 7) return $urandom();
    if (sel == 8) return 32'h8000_0000 + $urandom_range(0, 3);
    return 32'h7fff_ffff - $urandom_range(0, 3);
  endfunction

  initial begin
    logic [31:0] base, kb, ke, lk;
    logic [31:0] cfg_values[5];
    cfg_values = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0};
    cfg_values[4] = $urandom();

    // Directed part, starting from the reset contents.
    push_item(OP_LOOKUP, '0, '0, '0, 32'h8000_0000);
    push_item(OP_ASSIGN, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, $urandom());
    push_item(OP_LOOKUP, $urandom(), $urandom(), $urandom(), 32'h8000_0000);
    push_item(OP_LOOKUP, '0, '0, '0, 32'h7fff_ffff);
    push_item(OP_ASSIGN, 32'd10, 32'd10, 32'h1234_5678, '0);
    push_item(OP_ASSIGN, 32'd20, 32'hffff_fff0, 32'h1, '0);
    push_item(OP_ASSIGN, 32'hffff_fff0, 32'd20, 32'h8000_0000, 32'hffff_ffff);
    push_item(OP_LOOKUP, '0, '0, '0, 32'hffff_fff0);
    push_item(OP_LOOKUP, '0, '0, '0, 32'd19);
    push_item(OP_LOOKUP, '0, '0, '0, 32'd20);
    push_item(OP_ASSIGN, 32'd0, 32'd5, 32'hdead_beef, '0);
    push_item(OP_ASSIGN, 32'd5, 32'd8, 32'h0, '0);
    push_item(OP_LOOKUP, '0, '0, '0, 32'd5);
    push_item(OP_LOOKUP, '0, '0, '0, 32'd8);
    push_item(OP_ASSIGN, 32'hffff_ff00, 32'd100, 32'hffff_ffff, '0);
    push_item(OP_LOOKUP, '0, '0, '0, 32'd99);
    push_item(OP_LOOKUP, '0, '0, '0, 32'd100);
    push_item(OP_ASSIGN, 32'h7fff_fffe, 32'h7fff_ffff, 32'h5555_aaaa, '0);
    push_item(OP_LOOKUP, '0, '0, '0, 32'h7fff_ffff);
    push_marker(RQ_DRAIN, '0);

    // Random phases, each under a new initial_value.
    for (int ph = 0; ph < 5; ph++) begin
      push_marker(RQ_CFG, cfg_values[ph]);
      base = (ph == 3) ? $urandom() : 32'hffff_ff80 + $urandom_range(0, 256);
      for (int i = 0; i < 306; i++) begin
        quiet_gaps = ((i / 40) % 3 == 1);
        if (i % 97 == 96) push_marker(RQ_DRAIN, '0);
        kb = draw_key(base);
        ke = ($urandom_range(0, 9) < 8) ? kb + $urandom_range(1, 12) : draw_key(base);
        lk = draw_key(base);
        if ($urandom_range(0, 9) < 5)
          push_item(OP_ASSIGN, kb, ke, $urandom(), $urandom());
        else
          push_item(OP_LOOKUP, $urandom(), $urandom(), $urandom(), lk);
      end
      if (ph == 4) push_marker(RQ_CFG, $urandom());
    end

    wait (rst_n);
    wait (pending_reqs.size() == 0 && !drv_active && expected_results.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d requests (%0d lookups) across %0d settings of initial_value.",
             n_items, n_lookups, n_cfg);
    $display("Saw %0d empty-interval and %0d table-full results.", n_empty, n_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("interval_range_assign_table: match");
    end else begin
      $display("interval_range_assign_table: mismatch");
    end
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #20ms;
    $display("interval_range_assign_table: mismatch");
    $finish;
  end

endmodule
